// ===== sv/bounded_matrix_multiply_assert.svh =====
// Assertion macros shared by the matrix multiply modules.
`ifndef BOUNDED_MATRIX_MULTIPLY_ASSERT_SVH
`define BOUNDED_MATRIX_MULTIPLY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded_matrix_multiply: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounded_matrix_multiply: next-cycle check failed");

`endif

// ===== sv/bmm_pkg.sv =====
`timescale 1ns / 1ps

package bmm_pkg;

  // Default tile edge.
  localparam int unsigned DIM_DEFAULT = 8;

  // Word width of elements, products and tags.
  localparam int unsigned DATA_W = 32;

  // Configuration register width, index width and reset value.
  localparam int unsigned CFG_W = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_OF_A  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_OF_B  = 2'd2;

  // Operation codes of an input word.
  localparam logic OP_LOAD_A = 1'b0;
  localparam logic OP_LOAD_B = 1'b1;

  // Job queue between the loader and the compute engine.
  localparam int unsigned JOBQ_DEPTH = 2;
  localparam int unsigned JOBQ_PTR_W = $clog2(JOBQ_DEPTH);

  // Raw configuration register values.
  typedef struct packed {
    logic [CFG_W-1:0] rows_of_a;
    logic [CFG_W-1:0] inner_size;
    logic [CFG_W-1:0] cols_of_b;
  } cfg_t;

endpackage

// ===== sv/bmm_ram.sv =====
`timescale 1ns / 1ps

module bmm_ram #(
  parameter int unsigned WIDTH = bmm_pkg::DATA_W,
  parameter int unsigned DEPTH = bmm_pkg::DIM_DEFAULT * bmm_pkg::DIM_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds when idle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/bmm_job_fifo.sv =====
`timescale 1ns / 1ps

module bmm_job_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [bmm_pkg::DATA_W-1:0]  push_tag,
  output logic                        full,
  input  logic                        pop,
  output logic                        avail,
  output logic [bmm_pkg::DATA_W-1:0]  head_tag
);

  import bmm_pkg::*;

  logic [DATA_W-1:0]     slots [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr;
  logic [JOBQ_PTR_W-1:0] rd_ptr;
  logic [JOBQ_PTR_W:0]   count;

  assign full     = (count == (JOBQ_PTR_W + 1)'(JOBQ_DEPTH));
  assign avail    = (count != '0);
  assign head_tag = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tag;
    end
  end

endmodule

// ===== sv/bmm_front.sv =====
`timescale 1ns / 1ps
`include "bounded_matrix_multiply_assert.svh"

module bmm_front #(
  parameter int unsigned DIM = bmm_pkg::DIM_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           operation,
  input  logic [bmm_pkg::DATA_W-1:0]     element,
  input  logic [bmm_pkg::DATA_W-1:0]     job_tag,
  input  logic                           compute_done,
  input  logic                           job_full,
  output logic                           a_wr_en,
  output logic                           b_wr_en,
  output logic [$clog2(DIM*DIM)-1:0]     a_wr_addr,
  output logic [$clog2(DIM*DIM)-1:0]     b_wr_addr,
  output logic [bmm_pkg::DATA_W-1:0]     wr_data,
  output logic                           job_push,
  output logic [bmm_pkg::DATA_W-1:0]     job_push_tag
);

  import bmm_pkg::*;

  localparam int unsigned TW    = DIM * DIM;
  localparam int unsigned AW    = $clog2(TW);
  localparam int unsigned CNT_W = $clog2(TW + 1);

  logic [CNT_W-1:0] a_cnt;
  logic [CNT_W-1:0] b_cnt;
  logic             tiles_busy;
  logic             accept;
  logic             a_full;
  logic             b_last;

  // Classify the accepted word: load A, load B, or drop it.
  assign accept    = in_valid && in_ready;
  assign a_full    = (a_cnt == CNT_W'(TW));
  assign b_last    = (b_cnt == CNT_W'(TW - 1));
  assign a_wr_en   = accept && (operation == OP_LOAD_A) && !a_full;
  assign b_wr_en   = accept && (operation == OP_LOAD_B) && a_full;
  assign a_wr_addr = a_cnt[AW-1:0];
  assign b_wr_addr = b_cnt[AW-1:0];
  assign wr_data   = element;

  // The word that fills B hands a job to the compute engine.
  assign job_push     = b_wr_en && b_last;
  assign job_push_tag = job_tag;

  // Tiles are frozen from job hand-off until the engine has read them.
  assign in_ready = !tiles_busy && !job_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_cnt      <= '0;
      b_cnt      <= '0;
      tiles_busy <= 1'b0;
    end else begin
      if (compute_done) begin
        tiles_busy <= 1'b0;
      end
      if (job_push) begin
        a_cnt      <= '0;
        b_cnt      <= '0;
        tiles_busy <= 1'b1;
      end else begin
        if (a_wr_en) begin
          a_cnt <= a_cnt + 1'b1;
        end
        if (b_wr_en) begin
          b_cnt <= b_cnt + 1'b1;
        end
      end
    end
  end

  `BMM_ASSERT_SAME(a_front_push_needs_a, clk, rst, job_push, a_full)
  `BMM_ASSERT_SAME(a_front_busy_stalls, clk, rst, tiles_busy, !in_ready)
  `BMM_ASSERT_NEXT(a_front_push_sets_busy, clk, rst, job_push, tiles_busy && a_cnt == '0)

endmodule

// ===== sv/bmm_back.sv =====
`timescale 1ns / 1ps
`include "bounded_matrix_multiply_assert.svh"

module bmm_back #(
  parameter int unsigned DIM = bmm_pkg::DIM_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bmm_pkg::cfg_t                  cfg,
  input  logic                           job_avail,
  input  logic [bmm_pkg::DATA_W-1:0]     job_head_tag,
  output logic                           job_pop,
  output logic                           compute_done,
  output logic                           ab_rd_en,
  output logic [$clog2(DIM*DIM)-1:0]     a_rd_addr,
  output logic [$clog2(DIM*DIM)-1:0]     b_rd_addr,
  input  logic [bmm_pkg::DATA_W-1:0]     a_rd_data,
  input  logic [bmm_pkg::DATA_W-1:0]     b_rd_data,
  output logic                           c_wr_en,
  output logic [$clog2(DIM*DIM)-1:0]     c_wr_addr,
  output logic [bmm_pkg::DATA_W-1:0]     c_wr_data,
  output logic                           c_rd_en,
  output logic [$clog2(DIM*DIM)-1:0]     c_rd_addr,
  input  logic [bmm_pkg::DATA_W-1:0]     c_rd_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bmm_pkg::DATA_W-1:0]     product_element,
  output logic                           last_element,
  output logic [bmm_pkg::DATA_W-1:0]     job_tag_out
);

  import bmm_pkg::*;

  localparam int unsigned AW    = $clog2(DIM * DIM);
  localparam int unsigned IDX_W = $clog2(DIM);
  localparam int unsigned SZ_W  = $clog2(DIM + 1);

  typedef enum logic [3:0] {
    BK_IDLE    = 4'b0001,
    BK_COMPUTE = 4'b0010,
    BK_DRAIN   = 4'b0100,
    BK_EMIT    = 4'b1000
  } back_state_t;

  back_state_t       state;
  back_state_t       state_next;
  logic [SZ_W-1:0]   rows_eff;
  logic [SZ_W-1:0]   inner_eff;
  logic [SZ_W-1:0]   cols_eff;
  logic              sizes_zero;
  logic [DATA_W-1:0] job_tag_reg;

  // Compute loop counters and pipeline.
  logic [IDX_W-1:0]  ci;
  logic [IDX_W-1:0]  cj;
  logic [IDX_W-1:0]  ck;
  logic              i_last;
  logic              j_last;
  logic              k_last;
  logic              last_cell;
  logic              s1_valid;
  logic              s1_first;
  logic              s1_last;
  logic [AW-1:0]     s1_cidx;
  logic              s2_valid;
  logic              s2_first;
  logic              s2_last;
  logic [AW-1:0]     s2_cidx;
  logic [DATA_W-1:0] s2_prod;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] acc_sum;

  // Emission counters and read slot.
  logic [IDX_W-1:0]  er;
  logic [IDX_W-1:0]  ec;
  logic              issue_done;
  logic              emit_issue;
  logic              emit_move;
  logic              rd_valid;
  logic              rd_in_range;
  logic              rd_last;
  logic              er_last;
  logic              ec_last;

  // Effective sizes: capped at DIM, inner size at least one.
  always_comb begin
    rows_eff  = ({1'b0, cfg.rows_of_a} > (CFG_W + 1)'(DIM)) ? SZ_W'(DIM)
                                                            : SZ_W'(cfg.rows_of_a);
    cols_eff  = ({1'b0, cfg.cols_of_b} > (CFG_W + 1)'(DIM)) ? SZ_W'(DIM)
                                                            : SZ_W'(cfg.cols_of_b);
    if (cfg.inner_size == '0) begin
      inner_eff = SZ_W'(1);
    end else if ({1'b0, cfg.inner_size} > (CFG_W + 1)'(DIM)) begin
      inner_eff = SZ_W'(DIM);
    end else begin
      inner_eff = SZ_W'(cfg.inner_size);
    end
  end

  assign sizes_zero = (rows_eff == '0) || (cols_eff == '0);

  // Loop ends for the current cell and term.
  assign k_last    = (SZ_W'(ck) == inner_eff - SZ_W'(1));
  assign j_last    = (SZ_W'(cj) == cols_eff - SZ_W'(1));
  assign i_last    = (SZ_W'(ci) == rows_eff - SZ_W'(1));
  assign last_cell = k_last && j_last && i_last;

  // Read one A and one B element per cycle while computing.
  assign ab_rd_en  = (state == BK_COMPUTE);
  assign a_rd_addr = AW'(AW'(ci) * AW'(DIM) + AW'(ck));
  assign b_rd_addr = AW'(AW'(ck) * AW'(DIM) + AW'(cj));

  // Accumulate and write the finished cell.
  assign acc_sum   = (s2_first ? '0 : acc) + s2_prod;
  assign c_wr_en   = s2_valid && s2_last;
  assign c_wr_addr = s2_cidx;
  assign c_wr_data = acc_sum;

  // Emission: a read is issued when the read slot is empty or draining.
  assign er_last    = (er == IDX_W'(DIM - 1));
  assign ec_last    = (ec == IDX_W'(DIM - 1));
  assign emit_move  = rd_valid && (!out_valid || out_ready);
  assign emit_issue = (state == BK_EMIT) && !issue_done && (!rd_valid || emit_move);
  assign c_rd_en    = emit_issue;
  assign c_rd_addr  = AW'(AW'(er) * AW'(DIM) + AW'(ec));

  assign job_pop      = (state == BK_IDLE) && job_avail;
  assign compute_done = ((state == BK_DRAIN) && !s1_valid && !s2_valid)
                        || (job_pop && sizes_zero);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (job_avail) begin
          state_next = sizes_zero ? BK_EMIT : BK_COMPUTE;
        end
      end
      BK_COMPUTE: begin
        if (last_cell) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!s1_valid && !s2_valid) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (issue_done && !rd_valid) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      ci         <= '0;
      cj         <= '0;
      ck         <= '0;
      er         <= '0;
      ec         <= '0;
      issue_done <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= ab_rd_en;
      s2_valid <= s1_valid;

      if (job_pop) begin
        ci         <= '0;
        cj         <= '0;
        ck         <= '0;
        er         <= '0;
        ec         <= '0;
        issue_done <= 1'b0;
      end

      // Step k, then column, then row.
      if (ab_rd_en) begin
        if (k_last) begin
          ck <= '0;
          if (j_last) begin
            cj <= '0;
            ci <= ci + 1'b1;
          end else begin
            cj <= cj + 1'b1;
          end
        end else begin
          ck <= ck + 1'b1;
        end
      end

      // Walk the whole tile row-major for emission.
      if (emit_issue) begin
        if (ec_last) begin
          ec <= '0;
          if (er_last) begin
            issue_done <= 1'b1;
          end else begin
            er <= er + 1'b1;
          end
        end else begin
          ec <= ec + 1'b1;
        end
      end

      if (emit_issue) begin
        rd_valid <= 1'b1;
      end else if (emit_move) begin
        rd_valid <= 1'b0;
      end

      if (emit_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_tag_reg <= job_head_tag;
    end
    s1_first <= (ck == '0);
    s1_last  <= k_last;
    s1_cidx  <= AW'(AW'(ci) * AW'(DIM) + AW'(cj));
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_cidx  <= s1_cidx;
    s2_prod  <= a_rd_data * b_rd_data;
    if (s2_valid) begin
      acc <= acc_sum;
    end
    if (emit_issue) begin
      rd_in_range <= (SZ_W'(er) < rows_eff) && (SZ_W'(ec) < cols_eff);
      rd_last     <= er_last && ec_last;
    end
    if (emit_move) begin
      product_element <= rd_in_range ? c_rd_data : '0;
      last_element    <= rd_last;
      job_tag_out     <= job_tag_reg;
    end
  end

  `BMM_ASSERT_SAME(a_back_c_write_in_compute, clk, rst, c_wr_en,
                   state == BK_COMPUTE || state == BK_DRAIN)
  `BMM_ASSERT_SAME(a_back_emit_after_drain, clk, rst, state == BK_EMIT,
                   !s1_valid && !s2_valid)
  `BMM_ASSERT_NEXT(a_back_pop_starts_job, clk, rst, job_pop,
                   state == BK_COMPUTE || state == BK_EMIT)

endmodule

// ===== sv/bounded_matrix_multiply.sv =====
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// in       in_valid / in_ready    operation, element, job_tag
// out      out_valid / out_ready  product_element, last_element, job_tag_out
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each accepted word loads one element of A or B; the word that fills B hands a job on.
// The multiply runs one inner term per cycle on one multiplier; the input stalls from
// hand-off until the compute engine is done with the tiles, longer if the previous tile
// is still being emitted. Emission runs one word per cycle while out_ready stays high.
// Reset is synchronous and clears control state only; the tile memories need no clearing.
// A stalled output stalls emission only; the input keeps loading until the next job waits.

module bounded_matrix_multiply #(
  parameter int unsigned DIM = bmm_pkg::DIM_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             operation,
  input  logic signed [bmm_pkg::DATA_W-1:0] element,
  input  logic signed [bmm_pkg::DATA_W-1:0] job_tag,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [bmm_pkg::DATA_W-1:0] product_element,
  output logic                             last_element,
  output logic signed [bmm_pkg::DATA_W-1:0] job_tag_out,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmm_pkg::CFG_W-1:0]        cfg_data
);

  import bmm_pkg::*;

  localparam int unsigned TW = DIM * DIM;
  localparam int unsigned AW = $clog2(TW);

  cfg_t              cfg;
  logic              compute_done;
  logic              job_full;
  logic              job_push;
  logic [DATA_W-1:0] job_push_tag;
  logic              job_pop;
  logic              job_avail;
  logic [DATA_W-1:0] job_head_tag;
  logic              a_wr_en;
  logic              b_wr_en;
  logic [AW-1:0]     a_wr_addr;
  logic [AW-1:0]     b_wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              ab_rd_en;
  logic [AW-1:0]     a_rd_addr;
  logic [AW-1:0]     b_rd_addr;
  logic [DATA_W-1:0] a_rd_data;
  logic [DATA_W-1:0] b_rd_data;
  logic              c_wr_en;
  logic [AW-1:0]     c_wr_addr;
  logic [DATA_W-1:0] c_wr_data;
  logic              c_rd_en;
  logic [AW-1:0]     c_rd_addr;
  logic [DATA_W-1:0] c_rd_data;
  logic [DATA_W-1:0] product_word;
  logic [DATA_W-1:0] tag_word;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows_of_a  <= CFG_RESET;
      cfg.inner_size <= CFG_RESET;
      cfg.cols_of_b  <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROWS_OF_A:  cfg.rows_of_a  <= cfg_data;
        CFG_INNER_SIZE: cfg.inner_size <= cfg_data;
        CFG_COLS_OF_B:  cfg.cols_of_b  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bmm_front #(.DIM(DIM)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .element      (element),
    .job_tag      (job_tag),
    .compute_done (compute_done),
    .job_full     (job_full),
    .a_wr_en      (a_wr_en),
    .b_wr_en      (b_wr_en),
    .a_wr_addr    (a_wr_addr),
    .b_wr_addr    (b_wr_addr),
    .wr_data      (wr_data),
    .job_push     (job_push),
    .job_push_tag (job_push_tag)
  );

  bmm_job_fifo u_job_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_tag (job_push_tag),
    .full     (job_full),
    .pop      (job_pop),
    .avail    (job_avail),
    .head_tag (job_head_tag)
  );

  bmm_ram #(.WIDTH(DATA_W), .DEPTH(TW)) u_a_ram (
    .clk     (clk),
    .wr_en   (a_wr_en),
    .wr_addr (a_wr_addr),
    .wr_data (wr_data),
    .rd_en   (ab_rd_en),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  bmm_ram #(.WIDTH(DATA_W), .DEPTH(TW)) u_b_ram (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (b_wr_addr),
    .wr_data (wr_data),
    .rd_en   (ab_rd_en),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  bmm_ram #(.WIDTH(DATA_W), .DEPTH(TW)) u_c_ram (
    .clk     (clk),
    .wr_en   (c_wr_en),
    .wr_addr (c_wr_addr),
    .wr_data (c_wr_data),
    .rd_en   (c_rd_en),
    .rd_addr (c_rd_addr),
    .rd_data (c_rd_data)
  );

  bmm_back #(.DIM(DIM)) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .job_avail       (job_avail),
    .job_head_tag    (job_head_tag),
    .job_pop         (job_pop),
    .compute_done    (compute_done),
    .ab_rd_en        (ab_rd_en),
    .a_rd_addr       (a_rd_addr),
    .b_rd_addr       (b_rd_addr),
    .a_rd_data       (a_rd_data),
    .b_rd_data       (b_rd_data),
    .c_wr_en         (c_wr_en),
    .c_wr_addr       (c_wr_addr),
    .c_wr_data       (c_wr_data),
    .c_rd_en         (c_rd_en),
    .c_rd_addr       (c_rd_addr),
    .c_rd_data       (c_rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .product_element (product_word),
    .last_element    (last_element),
    .job_tag_out     (tag_word)
  );

  assign product_element = product_word;
  assign job_tag_out     = tag_word;

endmodule
